>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/ghash_pkg.sv
// ---------------------------------------------------------------------------
// ghash_pkg
// Types and constants for the streaming GHASH engine.
// ---------------------------------------------------------------------------
package ghash_pkg;

  localparam int unsigned FieldBits  = 128;
  localparam int unsigned WordBits   = 64;
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned CountBits  = 5;
  localparam int unsigned CfgIdxBits = 2;

  // Item actions
  typedef enum logic [1:0] {
    ActAad    = 2'd0,
    ActText   = 2'd1,
    ActFinish = 2'd2
  } ghash_action_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    CfgKeyHi = 2'd0,
    CfgKeyLo = 2'd1
  } ghash_cfg_e;

  typedef struct packed {
    logic [1:0]           action;
    logic [WordBits-1:0]  block_hi;
    logic [WordBits-1:0]  block_lo;
    logic [CountBits-1:0] byte_count;
  } ghash_in_t;

  typedef struct packed {
    logic [WordBits-1:0] hash_hi;
    logic [WordBits-1:0] hash_lo;
  } ghash_out_t;

endpackage

>>> rtl/ghash_gf_mult.sv
// ---------------------------------------------------------------------------
// ghash_gf_mult
// Combinational GF(2^128) multiply in GCM bit order (MSB of the word is
// the x^0 coefficient), reduced by x^128 + x^7 + x^2 + x + 1.
// ---------------------------------------------------------------------------
module ghash_gf_mult
  import ghash_pkg::*;
(
  input  logic [FieldBits-1:0] a_i,
  input  logic [FieldBits-1:0] b_i,
  output logic [FieldBits-1:0] p_o
);

  localparam int unsigned ProdBits = 2 * FieldBits - 1;
  localparam int unsigned HighBits = ProdBits - FieldBits;
  localparam int unsigned FoldBits = FieldBits + 6;

  logic [FieldBits-1:0] a_poly;
  logic [FieldBits-1:0] b_poly;
  logic [ProdBits-1:0]  prod;
  logic [FoldBits-1:0]  high_ext;
  logic [FoldBits-1:0]  fold1;
  logic [FieldBits-1:0] top_ext;
  logic [FieldBits-1:0] fold2;

  // GCM words are bit-reflected polynomials
  always_comb begin
    for (int i = 0; i < FieldBits; i++) begin
      a_poly[i] = a_i[FieldBits-1-i];
      b_poly[i] = b_i[FieldBits-1-i];
    end
  end

  // Carry-less partial products, summed as an XOR tree
  always_comb begin
    prod = '0;
    for (int i = 0; i < FieldBits; i++) begin
      prod = prod ^ (({{(ProdBits-FieldBits){1'b0}}, b_poly} &
                      {ProdBits{a_poly[i]}}) << i);
    end
  end

  // First fold: x^128 = x^7 + x^2 + x + 1, leaves degree up to 133
  assign high_ext = {{(FoldBits-HighBits){1'b0}}, prod[ProdBits-1:FieldBits]};
  assign fold1 = {6'b0, prod[FieldBits-1:0]} ^ high_ext ^ (high_ext << 1) ^
                 (high_ext << 2) ^ (high_ext << 7);

  // Second fold of the six overflow bits
  assign top_ext = {{(FieldBits-6){1'b0}}, fold1[FoldBits-1:FieldBits]};
  assign fold2 = fold1[FieldBits-1:0] ^ top_ext ^ (top_ext << 1) ^
                 (top_ext << 2) ^ (top_ext << 7);

  // Back to GCM bit order
  always_comb begin
    for (int i = 0; i < FieldBits; i++) begin
      p_o[i] = fold2[FieldBits-1-i];
    end
  end

endmodule

>>> rtl/gcm_ghash_engine.sv
// ---------------------------------------------------------------------------
// gcm_ghash_engine
// Streaming GHASH: masks and absorbs blocks, emits the hash on finish.
// ---------------------------------------------------------------------------
//   Write the hash subkey through the config channel (index 0 = bytes 0..7,
//   index 1 = bytes 8..15) while the engine is idle; cfg_ready_o is always 1.
//   Send items on the in channel: action 0 = AAD block, 1 = ciphertext
//   block, 2 = finish; action 3 is dropped. byte_count picks the valid
//   leading bytes (0 skips the block, above 16 counts as 16).
//   A finish returns one hash on the out channel. The finish transfer loads
//   the input register; with the result register free, masking, length
//   fold and one full 128x128 GF multiply then load the result register,
//   which raises out_valid_o, and the accumulator is cleared.
//   Throughput is one item per cycle, set by the accumulator feedback
//   through the single GF multiplier, while no finish waits on a pending hash.
//   While the receiver stalls, data blocks keep flowing; a finish that meets
//   a pending hash waits in the input register and in_ready_o stays low
//   until that hash is taken.
//   Reset clears key, accumulator, byte totals and both valid flags; a
//   finish clears accumulator and totals and keeps the key.
// ---------------------------------------------------------------------------
module gcm_ghash_engine
  import ghash_pkg::*;
#(
  parameter int unsigned LENGTH_COUNTER_BITS = 61
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [WordBits-1:0]   cfg_data_i,
  // input item channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ghash_in_t             in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ghash_out_t            out_data_o
);

  `include "assert_macros.svh"

  localparam int unsigned LenBits = LENGTH_COUNTER_BITS;
  localparam logic [LenBits-1:0] LenLimit = {LenBits{1'b1}};

  // Registers
  logic [WordBits-1:0]  key_hi_q, key_lo_q;
  logic [FieldBits-1:0] acc_q, acc_d;
  logic [LenBits-1:0]   aad_total_q, aad_total_d;
  logic [LenBits-1:0]   text_total_q, text_total_d;
  logic                 s1_valid_q, s1_valid_d;
  ghash_in_t            s1_data_q;
  logic                 out_valid_q, out_valid_d;
  ghash_out_t           out_data_q;

  // Stage logic
  logic                 in_fire;
  logic                 s1_fire;
  logic                 finish_fire;
  logic                 hash_blocked;
  logic                 is_data;
  logic                 is_finish;
  logic                 absorb;
  logic                 state_zero;
  logic [CountBits-1:0] n_bytes;
  logic [FieldBits-1:0] byte_mask;
  logic [FieldBits-1:0] len_block;
  logic [FieldBits-1:0] mult_in;
  logic [FieldBits-1:0] mult_out;
  logic [LenBits:0]     aad_sum, text_sum;
  logic [LenBits-1:0]   aad_sat, text_sat;

  // ---- config writes ----
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgKeyHi: key_hi_q <= cfg_data_i;
        CfgKeyLo: key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- handshake ----
  assign is_data   = (s1_data_q.action == ActAad) || (s1_data_q.action == ActText);
  assign is_finish = (s1_data_q.action == ActFinish);
  // only a finish needs room in the result register
  assign hash_blocked = out_valid_q && !out_ready_i;
  assign s1_fire      = s1_valid_q && (!is_finish || !hash_blocked);
  assign finish_fire  = s1_fire && is_finish;
  assign in_ready_o   = !s1_valid_q || s1_fire;
  assign in_fire      = in_valid_i && in_ready_o;

  assign s1_valid_d = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
  end

  // ---- byte masking ----
  assign n_bytes = (s1_data_q.byte_count > CountBits'(BlockBytes)) ?
                   CountBits'(BlockBytes) : s1_data_q.byte_count;
  assign absorb  = is_data && (n_bytes != '0);

  always_comb begin
    for (int b = 0; b < BlockBytes; b++) begin
      byte_mask[FieldBits-1-8*b -: 8] = (CountBits'(b) < n_bytes) ? 8'hff : 8'h00;
    end
  end

  // ---- length block: 64-bit big-endian bit counts ----
  assign len_block = {({{(WordBits-LenBits){1'b0}}, aad_total_q} << 3),
                      ({{(WordBits-LenBits){1'b0}}, text_total_q} << 3)};

  assign mult_in = is_finish ? (acc_q ^ len_block) :
                   (acc_q ^ ({s1_data_q.block_hi, s1_data_q.block_lo} & byte_mask));

  ghash_gf_mult u_gf_mult (
    .a_i (mult_in),
    .b_i ({key_hi_q, key_lo_q}),
    .p_o (mult_out)
  );

  // ---- saturating byte totals ----
  assign aad_sum  = {1'b0, aad_total_q} + {{(LenBits+1-CountBits){1'b0}}, n_bytes};
  assign text_sum = {1'b0, text_total_q} + {{(LenBits+1-CountBits){1'b0}}, n_bytes};
  assign aad_sat  = aad_sum[LenBits] ? LenLimit : aad_sum[LenBits-1:0];
  assign text_sat = text_sum[LenBits] ? LenLimit : text_sum[LenBits-1:0];

  // ---- state update ----
  always_comb begin
    acc_d        = acc_q;
    aad_total_d  = aad_total_q;
    text_total_d = text_total_q;
    if (s1_fire) begin
      if (is_finish) begin
        acc_d        = '0;
        aad_total_d  = '0;
        text_total_d = '0;
      end else if (absorb) begin
        acc_d = mult_out;
        if (s1_data_q.action == ActAad) begin
          aad_total_d = aad_sat;
        end else begin
          text_total_d = text_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      aad_total_q  <= '0;
      text_total_q <= '0;
    end else begin
      acc_q        <= acc_d;
      aad_total_q  <= aad_total_d;
      text_total_q <= text_total_d;
    end
  end

  // ---- result register ----
  assign out_valid_d = finish_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      out_data_q.hash_hi <= mult_out[FieldBits-1:WordBits];
      out_data_q.hash_lo <= mult_out[WordBits-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---- assertions ----
  assign state_zero = (acc_q == '0) && (aad_total_q == '0) && (text_total_q == '0);

  `ASSERT_RST(a_finish_gives_result, finish_fire |=> out_valid_q, "finish lost its result")
  `ASSERT_RST(a_finish_clears, finish_fire |=> state_zero, "finish did not clear state")
  `ASSERT_RST(a_stall_cause, !in_ready_o |-> (is_finish && hash_blocked), "needless input stall")
  `ASSERT_RST(a_skip_holds, s1_fire && !is_finish && !absorb |=> $stable(acc_q), "skip moved acc_q")

endmodule

>>> sim/tb_gcm_ghash_engine.sv
// ---------------------------------------------------------------------------
// tb_gcm_ghash_engine
// Self-checking bench for the streaming GHASH engine. A bit-exact GF(2^128)
// predictor tracks accumulator, byte totals and subkey, and queues one hash
// per finish transfer. The bench covers directed corner blocks and random
// message traffic with random stalls on both channels.
// ---------------------------------------------------------------------------
module tb_gcm_ghash_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ghash_pkg::*;

  // Byte total width as built
  localparam int unsigned TotalBits   = 61;
  localparam int unsigned MaxGap      = 16;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned ItemBudget  = 1850;
  localparam longint unsigned CycleLimit = 1_000_000;

  // Codes with no named member in the package
  localparam logic [1:0]            ActIgnored = 2'd3;
  localparam logic [CfgIdxBits-1:0] CfgSpareA  = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgSpareB  = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [WordBits-1:0]   cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  ghash_in_t             in_data;
  logic                  out_valid;
  logic                  out_ready;
  ghash_out_t            out_data;

  // Predictor state
  logic [FieldBits-1:0] pred_key;
  logic [FieldBits-1:0] pred_acc;
  logic [63:0]          pred_aad_bytes;
  logic [63:0]          pred_text_bytes;
  ghash_out_t           expected_hashes[$];
  ghash_out_t           hash_want;

  bit              quiet;
  int unsigned     stall_left;
  int unsigned     fail_count;
  int unsigned     sent_items;
  longint unsigned cycle_count = 0;

  gcm_ghash_engine #(
    .LENGTH_COUNTER_BITS(TotalBits)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // x * h in GF(2^128), bit 0 = MSB of byte 0
  function automatic logic [FieldBits-1:0] gf_mul(logic [FieldBits-1:0] x,
                                                  logic [FieldBits-1:0] h);
    logic [FieldBits-1:0] prod;
    logic [FieldBits-1:0] v;
    logic                 lsb;
    prod = '0;
    v    = x;
    for (int k = 0; k < FieldBits; k++) begin
      if (h[FieldBits-1-k]) prod ^= v;
      lsb = v[0];
      v   = v >> 1;
      if (lsb) v[FieldBits-1 -: 8] ^= 8'hE1;
    end
    return prod;
  endfunction

  function automatic logic [63:0] add_bytes_sat(logic [63:0] total, int unsigned n);
    logic [63:0] lim;
    lim = (64'd1 << TotalBits) - 64'd1;
    if (total >= lim || 64'(n) > lim - total) return lim;
    return total + 64'(n);
  endfunction

  // Apply one accepted item; a finish queues the expected hash
  function automatic void ghash_absorb(ghash_in_t item);
    int unsigned          n;
    logic [FieldBits-1:0] mask;
    ghash_out_t           hash;
    n = item.byte_count;
    if (item.action == ActAad || item.action == ActText) begin
      if (n == 0) return;
      if (n > BlockBytes) n = BlockBytes;
      mask = {FieldBits{1'b1}} << (8 * (BlockBytes - n));
      pred_acc = gf_mul(pred_acc ^ ({item.block_hi, item.block_lo} & mask), pred_key);
      if (item.action == ActAad) pred_aad_bytes = add_bytes_sat(pred_aad_bytes, n);
      else pred_text_bytes = add_bytes_sat(pred_text_bytes, n);
    end else if (item.action == ActFinish) begin
      pred_acc = gf_mul(pred_acc ^ {pred_aad_bytes << 3, pred_text_bytes << 3}, pred_key);
      hash.hash_hi = pred_acc[FieldBits-1 -: WordBits];
      hash.hash_lo = pred_acc[WordBits-1:0];
      expected_hashes.push_back(hash);
      pred_acc        = '0;
      pred_aad_bytes  = '0;
      pred_text_bytes = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall per transfer, compare against oldest hash
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_hashes.size() == 0) begin
        $error("unexpected hash transfer: %h", out_data);
        fail_count++;
      end else begin
        hash_want = expected_hashes.pop_front();
        if (out_data.hash_hi !== hash_want.hash_hi) begin
          $error("hash_hi: expected %h, actual %h", hash_want.hash_hi, out_data.hash_hi);
          fail_count++;
        end
        if (out_data.hash_lo !== hash_want.hash_lo) begin
          $error("hash_lo: expected %h, actual %h", hash_want.hash_lo, out_data.hash_lo);
          fail_count++;
        end
      end
      stall_left <= quiet ? 0 : $urandom_range(0, MaxGap);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [WordBits-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic ghash_in_t make_item(logic [1:0] action, logic [WordBits-1:0] hi,
                                          logic [WordBits-1:0] lo,
                                          logic [CountBits-1:0] count);
    ghash_in_t item;
    item.action     = action;
    item.block_hi   = hi;
    item.block_lo   = lo;
    item.byte_count = count;
    return item;
  endfunction

  // Mostly full blocks, some partial, some oversized, a few skipped
  function automatic logic [CountBits-1:0] random_count();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return CountBits'(BlockBytes);
    if (pick < 86) return CountBits'($urandom_range(1, BlockBytes - 1));
    if (pick < 93) return CountBits'($urandom_range(BlockBytes + 1, (1 << CountBits) - 1));
    return '0;
  endfunction

  // One input transfer after a random gap
  task automatic send_item(input ghash_in_t item);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MaxGap);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    ghash_absorb(item);
    sent_items++;
  endtask

  // Wait until every hash is out and the pipeline has emptied
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [WordBits-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgKeyHi) pred_key[FieldBits-1 -: WordBits] = value;
    else if (idx == CfgKeyLo) pred_key[WordBits-1:0] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_key(input logic [WordBits-1:0] hi, input logic [WordBits-1:0] lo);
    drain();
    write_reg(CfgKeyHi, hi);
    write_reg(CfgKeyLo, lo);
  endtask

  // One message: data blocks, stray ignored items, then a finish
  task automatic send_message(input int unsigned aad_blocks, input int unsigned text_blocks,
                              input bit mixed);
    int unsigned          aad_left;
    int unsigned          text_left;
    logic [1:0]           act;
    logic [CountBits-1:0] cnt;
    aad_left  = aad_blocks;
    text_left = text_blocks;
    while (aad_left + text_left != 0) begin
      if ($urandom_range(0, 19) == 0)
        send_item(make_item(ActIgnored, rand_word(), rand_word(), CountBits'($urandom)));
      if (aad_left == 0) act = ActText;
      else if (text_left == 0) act = ActAad;
      else if (mixed) act = $urandom_range(0, 1) ? ActText : ActAad;
      else act = ActAad;
      cnt = random_count();
      send_item(make_item(act, rand_word(), rand_word(), cnt));
      if (act == ActAad) aad_left--;
      else text_left--;
    end
    send_item(make_item(ActFinish, rand_word(), rand_word(), CountBits'($urandom)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Subkey resets to zero: every hash is zero
  task automatic test_reset_state();
    send_item(make_item(ActAad, rand_word(), rand_word(), CountBits'(BlockBytes)));
    send_item(make_item(ActFinish, rand_word(), rand_word(), '0));
    send_item(make_item(ActFinish, rand_word(), rand_word(), '0));
  endtask

  // Identity subkey, then writes to unused indexes must not touch the key
  task automatic test_register_writes();
    set_key(64'h8000_0000_0000_0000, 64'h0);
    write_reg(CfgSpareA, rand_word());
    write_reg(CfgSpareB, rand_word());
    send_item(make_item(ActAad, rand_word(), rand_word(), CountBits'(BlockBytes)));
    send_item(make_item(ActText, rand_word(), rand_word(), CountBits'(BlockBytes)));
    send_item(make_item(ActFinish, rand_word(), rand_word(), '0));
    set_key(64'h0, 64'h1);
    send_item(make_item(ActText, '1, '1, CountBits'(BlockBytes)));
    send_item(make_item(ActFinish, '0, '0, '1));
  endtask

  // Byte masking edges, skipped and ignored items, empty sections, mixed order
  task automatic test_directed_blocks();
    set_key('1, '1);
    send_item(make_item(ActAad, '1, '1, CountBits'(BlockBytes)));
    send_item(make_item(ActAad, '1, '1, CountBits'(1)));
    send_item(make_item(ActAad, '1, '1, CountBits'(8)));
    send_item(make_item(ActText, '1, '1, CountBits'(9)));
    send_item(make_item(ActText, rand_word(), rand_word(), CountBits'(15)));
    send_item(make_item(ActText, '1, '1, '0));
    send_item(make_item(ActText, '1, '1, '1));
    send_item(make_item(ActIgnored, '1, '1, '1));
    send_item(make_item(ActFinish, '1, '1, '1));
    // empty associated data
    send_item(make_item(ActText, '0, '0, CountBits'(BlockBytes)));
    send_item(make_item(ActText, rand_word(), rand_word(), CountBits'(7)));
    send_item(make_item(ActFinish, '0, '0, '0));
    // empty ciphertext
    send_item(make_item(ActAad, rand_word(), rand_word(), CountBits'(5)));
    send_item(make_item(ActFinish, rand_word(), rand_word(), '0));
    // nothing at all
    send_item(make_item(ActFinish, rand_word(), rand_word(), '0));
    // associated data after ciphertext, short block mid-stream
    send_item(make_item(ActText, rand_word(), rand_word(), CountBits'(BlockBytes)));
    send_item(make_item(ActAad, rand_word(), rand_word(), CountBits'(BlockBytes)));
    send_item(make_item(ActText, rand_word(), rand_word(), CountBits'(3)));
    send_item(make_item(ActText, rand_word(), rand_word(), CountBits'(BlockBytes)));
    send_item(make_item(ActFinish, rand_word(), rand_word(), '0));
  endtask

  // Random messages in phases, each phase with its own subkey and pacing
  task automatic test_random_traffic();
    int unsigned phase;
    phase = 0;
    while (sent_items < ItemBudget) begin
      case (phase)
        0:       set_key('1, '1);
        1:       set_key('0, '0);
        2:       set_key(64'h8000_0000_0000_0000, '0);
        3:       set_key('0, '1);
        default: set_key(rand_word(), rand_word());
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      for (int m = 0; m < 20 && sent_items < ItemBudget; m++)
        send_message($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 6) == 0);
      phase++;
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CfgKeyHi;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b1;
    stall_left      = 0;
    quiet           = 1'b0;
    fail_count      = 0;
    sent_items      = 0;
    pred_key        = '0;
    pred_acc        = '0;
    pred_aad_bytes  = '0;
    pred_text_bytes = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_register_writes();
    test_directed_blocks();
    test_random_traffic();
    drain();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ghash_pkg.sv
rtl/ghash_gf_mult.sv
rtl/gcm_ghash_engine.sv
sim/tb_gcm_ghash_engine.sv
